FILE: rtl/nearest_sorted_midpoint_distance_defines.svh
// Assertion shorthands for the checker file nsmd_chk.sv.
`ifndef NEAREST_SORTED_MIDPOINT_DISTANCE_DEFINES_SVH
`define NEAREST_SORTED_MIDPOINT_DISTANCE_DEFINES_SVH

// Same-cycle implication, idle in reset.
`define NSMD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle in reset.
`define NSMD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/nsmd_pkg.sv
`default_nettype none
package nsmd_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int CMD_W    = 2;
  localparam int CHROM_W  = 8;
  localparam int COORD_W  = 32;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ANSWERED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic [CHROM_W-1:0] chrom;
    logic [COORD_W-1:0] mid;
  } key_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    key_t             key;
  } job_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COORD_W-1:0]  distance;
  } res_t;

  typedef struct packed {
    logic               below;
    logic               chrom_eq;
    logic [COORD_W-1:0] gap;
  } alu_res_t;

endpackage
`default_nettype wire

FILE: rtl/nsmd_if.sv
`default_nettype none
interface nsmd_req_if import nsmd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [CHROM_W-1:0] chrom_id;
  logic [COORD_W-1:0] start_req;
  logic [COORD_W-1:0] stop;

  modport source (output valid, command, chrom_id, start_req, stop, input ready);
  modport sink   (input valid, command, chrom_id, start_req, stop, output ready);
endinterface

interface nsmd_rsp_if import nsmd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COORD_W-1:0]  distance;

  modport source (output valid, status, distance, input ready);
  modport sink   (input valid, status, distance, output ready);
endinterface
`default_nettype wire

FILE: rtl/nsmd_alu.sv
`default_nettype none
// Shared key compare and distance unit: entry read from the table vs query key.
module nsmd_alu import nsmd_pkg::*; (
  input  key_t     entry,
  input  key_t     query,
  input  logic     upper,
  output alu_res_t res
);

  logic chrom_lt;
  logic chrom_eq;
  logic mid_lt;
  logic mid_eq;

  always_comb begin
    chrom_lt     = entry.chrom < query.chrom;
    chrom_eq     = entry.chrom == query.chrom;
    mid_lt       = entry.mid < query.mid;
    mid_eq       = entry.mid == query.mid;
    res.chrom_eq = chrom_eq;
    // upper bound treats equal keys as below
    res.below    = chrom_lt || (chrom_eq && (mid_lt || (upper && mid_eq)));
    res.gap      = mid_lt ? (query.mid - entry.mid) : (entry.mid - query.mid);
  end

endmodule
`default_nettype wire

FILE: rtl/nsmd_seq.sv
`default_nettype none
// Sequencer: table memory, binary search, insert shift and neighbour pick.
module nsmd_seq import nsmd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  job_t job,
  input  logic res_free,
  output logic idle,
  output logic done,
  output res_t result
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_LEFT_RD,
    S_LEFT_CMP,
    S_RIGHT_RD,
    S_RIGHT_CMP,
    S_PICK,
    S_FINISH
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [CMD_W-1:0]   cmd;
  key_t               key;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi;
  logic [IDX_W-1:0]   probe;
  logic [CNT_W-1:0]   idx;
  logic               has_l;
  logic               has_r;
  logic [COORD_W-1:0] dist_l;
  logic [COORD_W-1:0] dist_r;
  res_t               res;

  key_t               table_mem [TABLE_DEPTH];
  key_t               rd_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  key_t               wr_data;

  logic [CNT_W-1:0]   mid_idx;
  logic [CNT_W-1:0]   lo_dec;
  logic [CNT_W-1:0]   idx_dec;
  alu_res_t           alu;

  assign mid_idx = lo + ((hi - lo) >> 1);
  assign lo_dec  = lo - CNT_W'(1);
  assign idx_dec = idx - CNT_W'(1);

  nsmd_alu u_alu (
    .entry (rd_data),
    .query (key),
    .upper (cmd == CMD_LOAD),
    .res   (alu)
  );

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = key;
    case (state)
      S_SRCH_RD: begin
        rd_en   = lo < hi;
        rd_addr = mid_idx[IDX_W-1:0];
      end
      S_SHIFT_RD: begin
        if (idx > lo) begin
          rd_en   = 1'b1;
          rd_addr = idx_dec[IDX_W-1:0];
        end else begin
          wr_en   = 1'b1;
          wr_addr = lo[IDX_W-1:0];
        end
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx[IDX_W-1:0];
        wr_data = rd_data;
      end
      S_LEFT_RD: begin
        rd_en   = lo != '0;
        rd_addr = lo_dec[IDX_W-1:0];
      end
      S_RIGHT_RD: begin
        rd_en   = lo < count;
        rd_addr = lo[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  assign idle   = state == S_IDLE;
  assign done   = (state == S_FINISH) && res_free;
  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd <= job.cmd;
            key <= job.key;
            lo  <= '0;
            hi  <= count;
            case (job.cmd)
              CMD_CLEAR: begin
                count <= '0;
                res   <= '{status: ST_CLEARED, distance: '0};
                state <= S_FINISH;
              end
              CMD_LOAD: begin
                if (count == CNT_W'(TABLE_DEPTH)) begin
                  res   <= '{status: ST_FULL, distance: '0};
                  state <= S_FINISH;
                end else begin
                  state <= S_SRCH_RD;
                end
              end
              CMD_QUERY: begin
                state <= S_SRCH_RD;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SRCH_RD: begin
          if (lo < hi) begin
            probe <= mid_idx[IDX_W-1:0];
            state <= S_SRCH_CMP;
          end else if (cmd == CMD_LOAD) begin
            idx   <= count;
            state <= S_SHIFT_RD;
          end else begin
            state <= S_LEFT_RD;
          end
        end
        S_SRCH_CMP: begin
          if (alu.below) begin
            lo <= CNT_W'(probe) + CNT_W'(1);
          end else begin
            hi <= CNT_W'(probe);
          end
          state <= S_SRCH_RD;
        end
        S_SHIFT_RD: begin
          if (idx > lo) begin
            state <= S_SHIFT_WR;
          end else begin
            count <= count + CNT_W'(1);
            res   <= '{status: ST_LOADED, distance: '0};
            state <= S_FINISH;
          end
        end
        S_SHIFT_WR: begin
          idx   <= idx_dec;
          state <= S_SHIFT_RD;
        end
        S_LEFT_RD: begin
          if (lo != '0) begin
            state <= S_LEFT_CMP;
          end else begin
            has_l <= 1'b0;
            state <= S_RIGHT_RD;
          end
        end
        S_LEFT_CMP: begin
          has_l  <= alu.chrom_eq;
          dist_l <= alu.gap;
          state  <= S_RIGHT_RD;
        end
        S_RIGHT_RD: begin
          if (lo < count) begin
            state <= S_RIGHT_CMP;
          end else begin
            has_r <= 1'b0;
            state <= S_PICK;
          end
        end
        S_RIGHT_CMP: begin
          has_r  <= alu.chrom_eq;
          dist_r <= alu.gap;
          state  <= S_PICK;
        end
        S_PICK: begin
          if (!has_l && !has_r) begin
            res <= '{status: ST_EMPTY, distance: '0};
          end else if (has_r && (!has_l || dist_r < dist_l)) begin
            res <= '{status: ST_ANSWERED, distance: dist_r};
          end else begin
            res <= '{status: ST_ANSWERED, distance: dist_l};
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/nearest_sorted_midpoint_distance.sv
`default_nettype none
// Nearest sorted midpoint distance. Keeps up to TABLE_DEPTH (1024) interval
// midpoints, (start_req + stop) / 2 rounded down, in a single-port-read table
// sorted by chromosome and then midpoint. Command 0 inserts a midpoint at its
// sorted place (after equal keys) and answers status 0, or status 1 when the
// table is full. Command 1 answers status 2 with the distance to the nearer
// neighbour of the query midpoint on the same chromosome, or status 3 if that
// chromosome holds no entries. Command 2 empties the table, status 4. Command 3
// is ignored and gives no item. One item is in work at a time; req.ready is
// low from acceptance until the result is handed to the output register.
// The table memory gives one registered read per cycle and is probed by a binary
// search, each step a read state and then a compare state. A clear, or a load
// into a full table, goes straight to the result. A query reads the left and
// then the right neighbour of the search point and picks the nearer. A load
// moves every entry above its insert position up one place, each by a read
// state and then a write state, before the new key is written.
// A finished result sits in the output register, so the next item may be
// accepted while it waits to be taken.
module nearest_sorted_midpoint_distance import nsmd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  nsmd_req_if.sink   req,
  nsmd_rsp_if.source rsp
);

  logic               seq_idle;
  logic               seq_done;
  logic               res_free;
  logic               start;
  job_t               job;
  res_t               seq_res;
  logic [COORD_W:0]   mid_sum;

  logic               out_valid;
  res_t               out_res;

  // midpoint from a carry-extended sum, so it never overflows
  assign mid_sum       = {1'b0, req.start_req} + {1'b0, req.stop};
  assign job.cmd       = req.command;
  assign job.key.chrom = req.chrom_id;
  assign job.key.mid   = mid_sum[COORD_W:1];

  assign req.ready = seq_idle;
  assign start     = req.valid && seq_idle;

  // output stage may load when empty or being drained this cycle
  assign res_free = !out_valid || rsp.ready;

  nsmd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .job      (job),
    .res_free (res_free),
    .idle     (seq_idle),
    .done     (seq_done),
    .result   (seq_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_done) begin
      out_valid <= 1'b1;
      out_res   <= seq_res;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_res.status;
  assign rsp.distance = out_res.distance;

endmodule
`default_nettype wire

FILE: rtl/nsmd_chk.sv
`default_nettype none
`include "nearest_sorted_midpoint_distance_defines.svh"
module nsmd_chk import nsmd_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic [CMD_W-1:0]    req_command,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [COORD_W-1:0]  rsp_distance
);

  logic cmd_known;

  // the unused command is dropped at once and leaves the block ready
  assign cmd_known = (req_command == CMD_LOAD) || (req_command == CMD_QUERY) ||
                     (req_command == CMD_CLEAR);

  // one item at a time: busy right after an acceptance
  `NSMD_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready && cmd_known, !req_ready, "ready held after accept")

  // a fresh result only follows a busy cycle
  `NSMD_ASSERT_IMP(a_result_from_work, clk, rst, $rose(rsp_valid), $past(!req_ready), "result without work")

  `NSMD_ASSERT_IMP(a_distance_zero, clk, rst, rsp_valid && (rsp_status != ST_ANSWERED), rsp_distance == '0, "distance set without answer")

  `NSMD_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_distance), "result dropped while stalled")

endmodule

bind nearest_sorted_midpoint_distance nsmd_chk u_nsmd_chk (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_command  (req.command),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_distance (rsp.distance)
);
`default_nettype wire

FILE: sim/tb_nearest_sorted_midpoint_distance.sv
`timescale 1ns / 1ps

// Self-checking bench for the nearest sorted midpoint distance block.
module tb_nearest_sorted_midpoint_distance;
  import nsmd_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;   // block ignores it, no item out
  localparam int KEY_W       = CHROM_W + COORD_W;
  localparam int ITEM_TARGET = 1400;
  localparam int QUIET_TAIL  = 150;   // last items go through with no idling
  localparam int HOLD_AFTER  = 250;   // accepted items before the long output hold
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [CHROM_W-1:0] chrom;
    logic [COORD_W-1:0] lo_coord;
    logic [COORD_W-1:0] hi_coord;
  } send_item_t;

  // how widely coordinates are spread in one random phase
  typedef enum logic [1:0] {SPREAD_NARROW, SPREAD_MID, SPREAD_WIDE, SPREAD_TOP} spread_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nsmd_req_if req_ch ();
  nsmd_rsp_if rsp_ch ();

  nearest_sorted_midpoint_distance dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  send_item_t items_to_send[$];     // stimulus not yet offered
  res_t       answers_due[$];       // predicted results, oldest first
  send_item_t cur_item;             // item on the request channel
  int         n_generated = 0;      // items that give a result
  int         items_accepted = 0;
  int         fail_count = 0;
  logic [31:0] cycle_no = '0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  // Predictor copy of the sorted store: each key is {chrom, midpoint}, so a plain
  // vector compare gives the chromosome-then-midpoint order.
  logic [KEY_W-1:0] db_key [TABLE_DEPTH];
  int               db_count = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Number of stored keys below key; with after_equal set, equal keys count too,
  // so a load lands behind its duplicates.
  function automatic int rank_of(logic [KEY_W-1:0] key, bit after_equal);
    int n;
    int i;
    n = 0;
    for (i = 0; i < db_count; i++)
      if (after_equal ? (db_key[i] <= key) : (db_key[i] < key)) n++;
    return n;
  endfunction

  function automatic logic [COORD_W-1:0] abs_gap(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Applies one item to the store; returns 0 where the item gives no result.
  function automatic bit table_step(input send_item_t it, output res_t ans);
    logic [COORD_W:0]   sum;
    logic [COORD_W-1:0] mid;
    logic [COORD_W-1:0] d_lo;
    logic [COORD_W-1:0] d_hi;
    logic [KEY_W-1:0]   key;
    int                 pos;
    int                 i;
    bit                 lo_ok;
    bit                 hi_ok;
    sum = {1'b0, it.lo_coord} + {1'b0, it.hi_coord};   // 33 bits, no overflow
    mid = sum[COORD_W:1];
    key = {it.chrom, mid};
    ans = '0;
    case (it.command)
      CMD_LOAD: begin
        if (db_count >= TABLE_DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          pos = rank_of(key, 1'b1);
          for (i = db_count; i > pos; i--) db_key[i] = db_key[i-1];
          db_key[pos] = key;
          db_count++;
          ans.status = ST_LOADED;
        end
      end
      CMD_QUERY: begin
        pos   = rank_of(key, 1'b0);
        lo_ok = (pos > 0) && (db_key[pos-1][KEY_W-1 -: CHROM_W] == it.chrom);
        hi_ok = (pos < db_count) && (db_key[pos][KEY_W-1 -: CHROM_W] == it.chrom);
        if (!lo_ok && !hi_ok) begin
          ans.status = ST_EMPTY;
        end else begin
          ans.status = ST_ANSWERED;
          d_lo = lo_ok ? abs_gap(mid, db_key[pos-1][COORD_W-1:0]) : '0;
          d_hi = hi_ok ? abs_gap(mid, db_key[pos][COORD_W-1:0]) : '0;
          if (lo_ok && hi_ok) ans.distance = (d_hi < d_lo) ? d_hi : d_lo;
          else                ans.distance = lo_ok ? d_lo : d_hi;
        end
      end
      CMD_CLEAR: begin
        db_count   = 0;
        ans.status = ST_CLEARED;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_item(input logic [CMD_W-1:0] c, input logic [CHROM_W-1:0] ch,
                           input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
    send_item_t it;
    it = '{command: c, chrom: ch, lo_coord: a, hi_coord: b};
    items_to_send.insert(items_to_send.size(), it);
    if (c != CMD_UNUSED) n_generated++;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(spread_t spread);
    case (spread)
      SPREAD_NARROW: return $urandom_range(0, 63);      // plenty of equal keys
      SPREAD_MID:    return $urandom_range(0, 65535);
      SPREAD_WIDE:   return $urandom;
      default:       return 32'hFFFF_FFFF - $urandom_range(0, 63);
    endcase
  endfunction

  // Clear, load a small set over a few chromosomes, then mostly queries.
  // The store holds at most 80 entries, which keeps inserts cheap.
  task automatic small_table_run();
    logic [CHROM_W-1:0] chroms [4];
    logic [CHROM_W-1:0] ch;
    spread_t            spread;
    int                 n_chroms;
    int                 n_loads;
    int                 n_ops;
    int                 roll;
    int                 i;
    n_chroms = $urandom_range(1, 4);
    for (i = 0; i < 4; i++) chroms[i] = CHROM_W'($urandom);
    spread = spread_t'($urandom_range(0, 3));
    push_item(CMD_CLEAR, CHROM_W'($urandom), $urandom, $urandom);
    n_loads = $urandom_range(0, 40);
    for (i = 0; i < n_loads; i++)
      push_item(CMD_LOAD, chroms[$urandom_range(0, n_chroms - 1)],
                pick_coord(spread), pick_coord(spread));
    n_ops = $urandom_range(8, 40);
    for (i = 0; i < n_ops; i++) begin
      roll = $urandom_range(0, 99);
      ch   = chroms[$urandom_range(0, n_chroms - 1)];
      if (roll < 70)      push_item(CMD_QUERY, ch, pick_coord(spread), pick_coord(spread));
      else if (roll < 78) push_item(CMD_QUERY, CHROM_W'($urandom), pick_coord(spread),
                                    pick_coord(spread));
      else if (roll < 90) push_item(CMD_LOAD, ch, pick_coord(spread), pick_coord(spread));
      else if (roll < 95) push_item(CMD_UNUSED, CHROM_W'($urandom), $urandom, $urandom);
      else                push_item(CMD_CLEAR, CHROM_W'($urandom), $urandom, $urandom);
    end
  endtask

  // Fill the whole store in ascending key order (each insert lands at the end,
  // so no entries move), then hit it with loads that must bounce and with
  // queries across the full depth.
  task automatic full_table_run();
    logic [CHROM_W-1:0] ch;
    logic [CHROM_W-1:0] first_ch;
    logic [COORD_W-1:0] mid;
    logic [COORD_W-1:0] step;
    int                 i;
    push_item(CMD_CLEAR, CHROM_W'($urandom), $urandom, $urandom);
    ch       = CHROM_W'($urandom_range(0, 3));
    first_ch = ch;
    mid      = $urandom_range(0, 1000);
    for (i = 0; i < TABLE_DEPTH; i++) begin
      push_item(CMD_LOAD, ch, mid, mid + $urandom_range(0, 1));   // rounds down to mid
      if ($urandom_range(0, 63) == 0 && ch < 250) begin
        ch  = CHROM_W'(ch + $urandom_range(1, 3));
        mid = $urandom_range(0, 1000);
      end else begin
        step = $urandom_range(0, 1 << 22);
        if (mid < 32'hFFFF_FFF0 - step) mid = mid + step;
      end
    end
    for (i = 0; i < 6; i++) push_item(CMD_LOAD, CHROM_W'($urandom), $urandom, $urandom);
    for (i = 0; i < 60; i++) begin
      if (i % 2 == 0) push_item(CMD_QUERY, CHROM_W'($urandom_range(first_ch, ch + 1)),
                                $urandom, $urandom);
      else push_item(CMD_QUERY, CHROM_W'($urandom_range(first_ch, ch + 1)),
                     $urandom_range(0, 1 << 30), $urandom_range(0, 1 << 30));
    end
    push_item(CMD_UNUSED, CHROM_W'($urandom), $urandom, $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: offers items from items_to_send, holds each until taken.
  // ---------------------------------------------------------------------------

  // No idling in the tail of the run, nor while cycle_no[8:7] is 3, a quarter of the time.
  function automatic bit idling_off();
    return (items_to_send.size() < QUIET_TAIL) || (cycle_no[8:7] == 2'b11);
  endfunction

  always @(posedge clk) cycle_no <= cycle_no + 1;

  always @(posedge clk) begin : request_driver
    send_item_t nxt;
    res_t       ans;
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left     <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        items_accepted <= items_accepted + 1;
        if (table_step(cur_item, ans)) answers_due.insert(answers_due.size(), ans);
      end
      // a stalled item stays on the channel untouched
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (gap_left != 0) begin
          gap_left     <= gap_left - 1;
          req_ch.valid <= 1'b0;
        end else if (items_to_send.size() == 0) begin
          req_ch.valid <= 1'b0;
        end else if (!idling_off() && $urandom_range(0, 7) == 0) begin
          gap_left     <= $urandom_range(0, 7);   // idle burst of random length
          req_ch.valid <= 1'b0;
        end else begin
          nxt              = items_to_send.pop_front();
          cur_item         <= nxt;
          req_ch.command   <= nxt.command;
          req_ch.chrom_id  <= nxt.chrom;
          req_ch.start_req <= nxt.lo_coord;
          req_ch.stop      <= nxt.hi_coord;
          req_ch.valid     <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus one long hold so the block backs up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : long_hold
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : result_ready
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (hold_left != 0) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!idling_off() && $urandom_range(0, 7) == 0) begin
      stall_left   <= $urandom_range(0, 7);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Each item taken is checked against the oldest prediction.
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (answers_due.size() == 0) begin
        $error("unexpected item: status %0d distance %0d", rsp_ch.status, rsp_ch.distance);
        fail_count++;
      end else begin
        want = answers_due.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, rsp_ch.distance);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus build, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    bit full_done;
    full_done        = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.command   = CMD_UNUSED;
    req_ch.chrom_id  = '0;
    req_ch.start_req = '0;
    req_ch.stop      = '0;
    rsp_ch.ready     = 1'b0;
    cur_item         = '0;

    // directed: edges of the fields and the named corner cases
    push_item(CMD_QUERY, 8'd7, 32'd10, 32'd10);                    // empty store
    push_item(CMD_LOAD, 8'd0, 32'd0, 32'd0);                       // midpoint 0
    push_item(CMD_LOAD, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);     // sum needs 33 bits
    push_item(CMD_LOAD, 8'd255, 32'hFFFF_FFFF, 32'd0);             // midpoint 7FFFFFFF
    push_item(CMD_LOAD, 8'd7, 32'd100, 32'd101);                   // rounds down to 100
    push_item(CMD_LOAD, 8'd7, 32'd101, 32'd100);                   // equal key again
    push_item(CMD_LOAD, 8'd7, 32'd300, 32'd300);
    push_item(CMD_QUERY, 8'd7, 32'd50, 32'd50);                    // below all: right only
    push_item(CMD_QUERY, 8'd7, 32'd1000, 32'd1000);                // above all: left only
    push_item(CMD_QUERY, 8'd7, 32'd200, 32'd200);                  // tie between neighbours
    push_item(CMD_QUERY, 8'd7, 32'd210, 32'd210);
    push_item(CMD_QUERY, 8'd7, 32'd99, 32'd102);                   // exact hit
    push_item(CMD_QUERY, 8'd8, 32'd100, 32'd100);                  // chromosome in a gap
    push_item(CMD_QUERY, 8'd255, 32'd0, 32'd0);
    push_item(CMD_QUERY, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);      // widest distance
    push_item(CMD_UNUSED, 8'd0, 32'd0, 32'd0);
    push_item(CMD_CLEAR, 8'd0, 32'd0, 32'd0);
    push_item(CMD_QUERY, 8'd7, 32'd100, 32'd100);                  // gone after clear
    push_item(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(CMD_CLEAR, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // random: small stores with one full-depth pass part way through
    while (n_generated < ITEM_TARGET) begin
      if (!full_done && n_generated >= 300) begin
        full_table_run();
        full_done = 1'b1;
      end else begin
        small_table_run();
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (items_to_send.size() != 0 || req_ch.valid) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    // an ignored item may still be in work; give it time to show up wrongly
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (answers_due.size() != 0) begin
      $error("%0d predicted items never arrived", answers_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
